/* rtl/dmd_pkg.sv */
// dmd_pkg: shared constants and types for the delimited message deframer
`timescale 1ns / 1ps

package dmd_pkg;

   localparam int FRAME_CAPACITY = 32;
   localparam int ADDR_W         = $clog2(FRAME_CAPACITY);
   localparam int CNT_W          = $clog2(FRAME_CAPACITY + 1);
   localparam int BYTE_W         = 8;
   localparam int LEN_W          = 6;
   localparam int CSR_IDX_W      = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_START_IDX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_IDX   = 2'd1;

   localparam logic [BYTE_W-1:0] START_RESET = 8'd91;
   localparam logic [BYTE_W-1:0] END_RESET   = 8'd93;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } dmd_state_type;

endpackage

/* rtl/dmd_frame_ram.sv */
// dmd_frame_ram: frame byte store, one write port and one registered read port
`timescale 1ns / 1ps

module dmd_frame_ram
   import dmd_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [FRAME_CAPACITY];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/delimited_message_deframer.sv */
// delimited_message_deframer: gathers delimited frames and plays them back bytewise
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  req_rx_byte[7:0], req_parity_bad
//   rsp_     out  rsp_valid/rsp_stall  rsp_frame_byte[7:0], rsp_frame_length[5:0],
//                                      rsp_frame_last
//   csr_     in   csr_valid/csr_ready  csr_index[1:0], csr_wdata[7:0]
//
// a byte that does not end a frame leaves req_stall low, so the next beat is taken right after
// an end byte holds off input (req_stall) until the read of the last frame byte is issued;
// the frame store is read on its single read port, one read per cycle unless rsp_stall holds it
// rsp_stall delays read-out, and so input, with no loss; the registered read and output stage absorb it
// reset is synchronous; it empties the frame and restores the delimiters (91, 93)
`timescale 1ns / 1ps

module delimited_message_deframer
   import dmd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic                 req_parity_bad,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_frame_byte,
   output logic [LEN_W-1:0]     rsp_frame_length,
   output logic                 rsp_frame_last,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   dmd_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] last_idx_ff, last_idx_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [BYTE_W-1:0] start_ff, end_ff;

   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;
   logic [CNT_W-1:0]  pend_len_ff, pend_len_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic              rsp_last_ff;

   logic              accept, good, is_end, is_start;
   logic              issue, load;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] rd_data;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         end_ff   <= END_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_IDX: start_ff <= csr_wdata;
            CSR_END_IDX:   end_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // intake
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign good      = accept && !req_parity_bad;
   assign is_end    = (req_rx_byte == end_ff);
   assign is_start  = (req_rx_byte == start_ff);

   assign wr_en   = good;
   assign wr_addr = (is_start && !is_end) ? '0 : fill_ff[ADDR_W-1:0];

   // read-out: a read is issued only when its data has a place to land
   assign load  = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue = (state_ff == ST_READ) && (!pend_ff || load);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      last_idx_in  = last_idx_ff;
      rd_ptr_in    = rd_ptr_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      pend_len_in  = pend_len_ff;
      rsp_valid_in = rsp_valid_ff;

      if (accept) begin
         if (req_parity_bad) begin
            fill_in = '0;
         end else if (is_end) begin
            len_in      = fill_ff + CNT_W'(1);
            last_idx_in = fill_ff[ADDR_W-1:0];
            rd_ptr_in   = '0;
            fill_in     = '0;
            state_in    = ST_READ;
         end else if (is_start) begin
            fill_in = CNT_W'(1);
         end else if (fill_ff + CNT_W'(1) == CNT_W'(FRAME_CAPACITY)) begin
            // full without an end byte: drop silently
            fill_in = '0;
         end else begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         pend_in      = 1'b0;
      end

      if (issue) begin
         pend_in      = 1'b1;
         pend_last_in = (rd_ptr_ff == last_idx_ff);
         pend_len_in  = len_ff;
         rd_ptr_in    = rd_ptr_ff + ADDR_W'(1);
         if (rd_ptr_ff == last_idx_ff) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      last_idx_ff  <= last_idx_in;
      rd_ptr_ff    <= rd_ptr_in;
      pend_last_ff <= pend_last_in;
      pend_len_ff  <= pend_len_in;
      if (load) begin
         rsp_byte_ff <= rd_data;
         rsp_len_ff  <= LEN_W'(pend_len_ff);
         rsp_last_ff <= pend_last_ff;
      end
   end

   dmd_frame_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = rsp_byte_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_frame_last   = rsp_last_ff;

   // the buffer never rests at capacity
   a_fill_below_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff < CNT_W'(FRAME_CAPACITY))
      else $error("fill count reached capacity");

   // an accepted end byte starts read-out
   a_end_starts_read: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_parity_bad && is_end) |=> (state_ff == ST_READ))
      else $error("end byte did not start read-out");

   // a new read never overwrites data that has not moved to the output stage
   a_no_read_overrun: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !load) |-> !issue)
      else $error("read issued over pending data");

   // read data that is pending stays pending until the output stage takes it
   a_pend_held: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && rsp_valid_ff && rsp_stall) |=> pend_ff)
      else $error("pending read data lost under stall");

endmodule

/* verif/delimited_message_deframer_tb.sv */
// delimited_message_deframer_tb: self-checking testbench with frame predictor and scoreboard
`timescale 1ns / 1ps

module delimited_message_deframer_tb;
   import dmd_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int GAP_PCT      = 25;

   // indexes with no register behind them, writes must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX_B = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              parity_bad;
   } rx_beat_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [LEN_W-1:0]  frame_length;
      logic              frame_last;
   } frame_beat_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 req_parity_bad = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_frame_byte;
   logic [LEN_W-1:0]     rsp_frame_length;
   logic                 rsp_frame_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_wdata = '0;

   rx_beat_type       rx_pending_q[$];
   frame_beat_type    frame_expect_q[$];
   logic [BYTE_W-1:0] frame_buf[$];
   logic [BYTE_W-1:0] start_delim = START_RESET;
   logic [BYTE_W-1:0] end_delim   = END_RESET;
   int                beats_in_flight = 0;
   int                phase_beats = 0;
   int                fail_count = 0;
   int                cycle_count = 0;
   bit                allow_gaps = 1'b1;

   delimited_message_deframer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_parity_bad   (req_parity_bad),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_last   (rsp_frame_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // frame assembly as the block should see it, one accepted byte at a time
   task automatic assemble_byte(input logic [BYTE_W-1:0] rx, input logic bad);
      frame_beat_type fb;
      int             n;
      if (bad) begin
         frame_buf.delete();
         return;
      end
      if (frame_buf.size() >= FRAME_CAPACITY)
         frame_buf.delete();
      frame_buf.push_back(rx);
      if (rx == end_delim) begin
         n = frame_buf.size();
         for (int k = 0; k < n; k++) begin
            fb.frame_byte   = frame_buf[k];
            fb.frame_length = LEN_W'(n);
            fb.frame_last   = (k == n - 1);
            frame_expect_q.push_back(fb);
         end
         frame_buf.delete();
      end else if (rx == start_delim) begin
         frame_buf.delete();
         frame_buf.push_back(rx);
      end else if (frame_buf.size() == FRAME_CAPACITY) begin
         frame_buf.delete();
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_rx_byte    <= '0;
         req_parity_bad <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            assemble_byte(req_rx_byte, req_parity_bad);
            beats_in_flight--;
         end
         if (!req_valid || !req_stall) begin
            if (rx_pending_q.size() != 0 &&
                !(allow_gaps && $urandom_range(0, 99) < GAP_PCT)) begin
               req_valid      <= 1'b1;
               req_rx_byte    <= rx_pending_q[0].rx_byte;
               req_parity_bad <= rx_pending_q[0].parity_bad;
               void'(rx_pending_q.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      frame_beat_type fb;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_expect_q.size() == 0) begin
               $error("unexpected frame beat: byte %0d length %0d last %0d",
                      rsp_frame_byte, rsp_frame_length, rsp_frame_last);
               fail_count++;
            end else begin
               fb = frame_expect_q.pop_front();
               if (rsp_frame_byte !== fb.frame_byte) begin
                  $error("frame_byte: expected %0d, got %0d", fb.frame_byte, rsp_frame_byte);
                  fail_count++;
               end
               if (rsp_frame_length !== fb.frame_length) begin
                  $error("frame_length: expected %0d, got %0d",
                         fb.frame_length, rsp_frame_length);
                  fail_count++;
               end
               if (rsp_frame_last !== fb.frame_last) begin
                  $error("frame_last: expected %0d, got %0d", fb.frame_last, rsp_frame_last);
                  fail_count++;
               end
            end
         end
         rsp_stall <= allow_gaps && ($urandom_range(0, 99) < GAP_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[delimited_message_deframer] ERROR");
         $finish;
      end
   end

   task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic bad = 1'b0);
      rx_beat_type beat;
      beat.rx_byte    = b;
      beat.parity_bad = bad;
      beats_in_flight++;
      phase_beats++;
      rx_pending_q.push_back(beat);
   endtask

   function automatic logic [BYTE_W-1:0] payload_byte();
      logic [BYTE_W-1:0] b;
      do
         b = BYTE_W'($urandom_range(0, 255));
      while (b == start_delim || b == end_delim);
      return b;
   endfunction

   task automatic queue_payload(input int n);
      for (int k = 0; k < n; k++)
         queue_byte(payload_byte());
   endtask

   task automatic queue_random_frame();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         queue_byte(start_delim);
         queue_payload($urandom_range(0, 6));
         queue_byte(end_delim);
      end else if (kind == 6) begin
         // line noise, anything goes
         repeat ($urandom_range(1, 4))
            queue_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else if (kind == 7) begin
         // corrupted byte mid-frame, only what follows it survives
         queue_byte(start_delim);
         queue_payload($urandom_range(0, 4));
         queue_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
         queue_payload($urandom_range(0, 3));
         queue_byte(end_delim);
      end else if (kind == 8) begin
         // frame abandoned without an end byte
         queue_byte(start_delim);
         queue_payload($urandom_range(0, 4));
      end else begin
         // second start byte restarts the frame
         queue_byte(start_delim);
         queue_payload($urandom_range(0, 4));
         queue_byte(start_delim);
         queue_payload($urandom_range(0, 4));
         queue_byte(end_delim);
      end
   endtask

   task automatic queue_random_frames(input int target);
      phase_beats = 0;
      while (phase_beats < target)
         queue_random_frame();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (beats_in_flight != 0 || frame_expect_q.size() != 0)
         @(negedge clock);
      // bytes that end no frame are not tracked by the expect queue; let the block settle
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_START_IDX)
         start_delim = val;
      else if (idx == CSR_END_IDX)
         end_delim = val;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default delimiters
      queue_byte(8'd93);                                   // lone end byte
      queue_byte(8'd91); queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'd93);
      queue_byte(8'd91); queue_byte(8'h12); queue_byte(8'd93, 1'b1);  // bad end byte
      queue_byte(8'h34); queue_byte(8'd93);
      queue_byte(8'd91); queue_byte(8'hAA); queue_byte(8'd91);        // restart
      queue_byte(8'h55); queue_byte(8'd93);
      queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'd93);        // no start byte
      wait_drained();

      // delimiters at the ends of the byte range, spare indexes ignored
      write_csr(CSR_START_IDX, 8'h00);
      write_csr(CSR_END_IDX, 8'hFF);
      write_csr(CSR_SPARE_IDX_A, 8'h80);
      @(negedge clock);
      queue_byte(8'h00); queue_byte(8'h80); queue_byte(8'hFF);
      queue_byte(8'hFF, 1'b1); queue_byte(8'h7F); queue_byte(8'hFF);
      wait_drained();

      // equal delimiters, end wins
      write_csr(CSR_START_IDX, 8'h5A);
      write_csr(CSR_END_IDX, 8'h5A);
      write_csr(CSR_SPARE_IDX_B, 8'hA5);
      @(negedge clock);
      queue_byte(8'h5A);
      queue_byte(8'h11); queue_byte(8'h5A);
      wait_drained();

      // random delimiters, full-buffer frames first, no gaps on either side
      allow_gaps = 1'b0;
      write_csr(CSR_START_IDX, BYTE_W'($urandom_range(0, 255)));
      write_csr(CSR_END_IDX, BYTE_W'($urandom_range(0, 255)));
      @(negedge clock);
      queue_byte(start_delim);
      queue_payload(FRAME_CAPACITY - 2);
      queue_byte(end_delim);                               // end byte in last slot
      queue_byte(start_delim);
      queue_payload(FRAME_CAPACITY - 1);                   // fills and is dropped
      queue_payload(2);
      queue_byte(end_delim);
      queue_random_frames(4);
      wait_drained();
      allow_gaps = 1'b1;

      write_csr(CSR_START_IDX, BYTE_W'($urandom_range(0, 255)));
      write_csr(CSR_END_IDX, BYTE_W'($urandom_range(0, 255)));
      @(negedge clock);
      queue_random_frames(4);
      wait_drained();

      write_csr(CSR_START_IDX, 8'hFF);
      write_csr(CSR_END_IDX, 8'h00);
      @(negedge clock);
      queue_random_frames(4);
      wait_drained();

      if (fail_count == 0)
         $display("[delimited_message_deframer] OK");
      else
         $display("[delimited_message_deframer] ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/dmd_pkg.sv
rtl/dmd_frame_ram.sv
rtl/delimited_message_deframer.sv
verif/delimited_message_deframer_tb.sv
